// ===== sv/wmv_pkg.sv =====
// shared constants, widths and state type of the sliding window statistics block
`timescale 1ns / 1ps

package wmv_pkg;

   localparam int WMV_SAMPLE_W     = 24;
   localparam int WMV_MEAN_W       = 24;
   localparam int WMV_VAR_W        = 48;
   localparam int WMV_LEN_W        = 9;
   localparam int WMV_LEN_RESET    = 16;
   localparam int WMV_WINDOW_DEPTH = 256;
   localparam int WMV_SAMPLE_BITS  = 24;

   typedef enum logic [2:0] {
      WMV_IDLE,
      WMV_READ,
      WMV_UPDATE,
      WMV_LOAD,
      WMV_DIVIDE,
      WMV_SQUARE,
      WMV_FINISH
   } wmv_state_type;

endpackage

// ===== sv/wmv_if.sv =====
// valid/ready channel interfaces for sample, result and window length transfers
`timescale 1ns / 1ps

interface wmv_req_if import wmv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [WMV_SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface wmv_rsp_if import wmv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WMV_MEAN_W-1:0] window_mean;
   logic [WMV_VAR_W-1:0]  window_variance;

   modport source (output valid, output window_mean, output window_variance, input ready);
   modport sink (input valid, input window_mean, input window_variance, output ready);
endinterface

interface wmv_csr_if import wmv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WMV_LEN_W-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink (input valid, input window_length, output ready);
endinterface

// ===== sv/window_mean_variance_unsigned.sv =====
// sliding window mean and variance of unsigned samples, ring held in one synchronous memory
//
// req_ch carries one sample per transfer, rsp_ch returns one result per sample: the floor
// mean of the window and floor(sum of squares / N) minus the mean squared. csr_ch writes the
// window length N (0 counts as 1, values above WINDOW_DEPTH count as WINDOW_DEPTH); any write
// restarts the statistics, and the next sample fills the whole window with copies of itself.
// One sample is processed at a time: after acceptance it passes the READ, UPDATE, LOAD, DIVIDE,
// SQUARE and FINISH steps, the result is presented from FINISH, and the next sample is taken
// once the block is back in IDLE. The bit-serial dividers in DIVIDE produce one quotient bit
// each per cycle over the width of the running sum of squares.
// The ring memory is read at the accepting edge and written back at the end of UPDATE.
// csr_ch is ready only while the block is idle and takes precedence over a sample.
// Reset returns the window length to 16 and restarts the statistics; the ring needs no clearing
// as unwritten entries are never read. A stalled receiver holds the result in the output
// register, the next sample is still accepted and processed, and its result waits until the
// held one has been transferred.
`timescale 1ns / 1ps

module window_mean_variance_unsigned import wmv_pkg::*; #(
   parameter int WINDOW_DEPTH = WMV_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = WMV_SAMPLE_BITS
) (
   input logic   clock,
   input logic   reset,
   wmv_req_if.sink   req_ch,
   wmv_rsp_if.source rsp_ch,
   wmv_csr_if.sink   csr_ch
);

   localparam int PW   = $clog2(WINDOW_DEPTH);
   localparam int NW   = $clog2(WINDOW_DEPTH + 1);
   localparam int CW   = (NW > WMV_LEN_W) ? NW : WMV_LEN_W;
   localparam int SUMW = SAMPLE_BITS + PW;
   localparam int SQ2  = 2 * SAMPLE_BITS;
   localparam int SQW  = SQ2 + PW;
   localparam int CNTW = $clog2(SQW);

   wmv_state_type state_ff, state_in;

   logic [WMV_LEN_W-1:0]   wl_ff, wl_in;
   logic [PW-1:0]          wpos_ff, wpos_in;
   logic                   primed_ff, primed_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [SUMW-1:0]        sum_ff, sum_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [SAMPLE_BITS-1:0] v_ff, v_in;
   logic [SAMPLE_BITS-1:0] old_ff, old_in;
   logic [SQ2-1:0]         vv_ff, vv_in;
   logic [SQ2-1:0]         oo_ff, oo_in;
   logic [SQW-1:0]         dq_s_ff, dq_s_in;
   logic [SQW-1:0]         dq_q_ff, dq_q_in;
   logic [NW-1:0]          rem_s_ff, rem_s_in;
   logic [NW-1:0]          rem_q_ff, rem_q_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [SQ2-1:0]         m2_ff, m2_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WMV_MEAN_W-1:0]  mean_ff, mean_in;
   logic [WMV_VAR_W-1:0]   var_ff, var_in;

   logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_ff;

   logic                   req_fire, csr_fire, rsp_fire, out_free;
   logic                   ring_we;
   logic [NW-1:0]          n;
   logic [CW-1:0]          wl_ext;
   logic [PW-1:0]          pos;
   logic [NW-1:0]          pos_next;
   logic [NW:0]            rs_s, rs_q;
   logic                   ge_s, ge_q;
   logic [SAMPLE_BITS-1:0] mean_q;
   logic [SQ2-1:0]         msq_q;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // effective window length
   always_comb begin
      wl_ext = CW'(wl_ff);
      if (wl_ext == '0) begin
         n = NW'(1);
      end else if (wl_ext > CW'(WINDOW_DEPTH)) begin
         n = NW'(WINDOW_DEPTH);
      end else begin
         n = NW'(wl_ext);
      end
   end

   assign pos      = (NW'(wpos_ff) >= n) ? '0 : wpos_ff;
   assign pos_next = NW'(pos) + NW'(1);

   assign rs_s   = {rem_s_ff, dq_s_ff[SQW-1]};
   assign rs_q   = {rem_q_ff, dq_q_ff[SQW-1]};
   assign ge_s   = rs_s >= {1'b0, n};
   assign ge_q   = rs_q >= {1'b0, n};
   assign mean_q = dq_s_ff[SAMPLE_BITS-1:0];
   assign msq_q  = dq_q_ff[SQ2-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WMV_IDLE: begin
            if (req_fire) state_in = WMV_READ;
         end
         WMV_READ:   state_in = WMV_UPDATE;
         WMV_UPDATE: state_in = WMV_LOAD;
         WMV_LOAD:   state_in = WMV_DIVIDE;
         WMV_DIVIDE: begin
            if (cnt_ff == CNTW'(SQW - 1)) state_in = WMV_SQUARE;
         end
         WMV_SQUARE: state_in = WMV_FINISH;
         WMV_FINISH: begin
            if (out_free) state_in = WMV_IDLE;
         end
         default:    state_in = WMV_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      csr_ch.ready = 1'b0;
      req_ch.ready = 1'b0;
      ring_we      = 1'b0;
      case (state_ff)
         WMV_IDLE: begin
            csr_ch.ready = 1'b1;
            req_ch.ready = !csr_ch.valid;
         end
         WMV_UPDATE: begin
            ring_we = primed_ff;
         end
         default: begin
            csr_ch.ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      wl_in        = wl_ff;
      wpos_in      = wpos_ff;
      primed_in    = primed_ff;
      wrapped_in   = wrapped_ff;
      first_in     = first_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      v_in         = v_ff;
      old_in       = old_ff;
      vv_in        = vv_ff;
      oo_in        = oo_ff;
      dq_s_in      = dq_s_ff;
      dq_q_in      = dq_q_ff;
      rem_s_in     = rem_s_ff;
      rem_q_in     = rem_q_ff;
      cnt_in       = cnt_ff;
      m2_in        = m2_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      if (csr_fire) begin
         wl_in      = csr_ch.window_length;
         wpos_in    = '0;
         primed_in  = 1'b0;
         wrapped_in = 1'b0;
         first_in   = '0;
         sum_in     = '0;
         sq_in      = '0;
      end
      if (req_fire) begin
         v_in = req_ch.sample[SAMPLE_BITS-1:0];
      end
      case (state_ff)
         WMV_READ: begin
            old_in = wrapped_ff ? rd_ff : first_ff;
            vv_in  = SQ2'(v_ff) * SQ2'(v_ff);
            oo_in  = SQ2'(old_in) * SQ2'(old_in);
         end
         WMV_UPDATE: begin
            if (!primed_ff) begin
               primed_in = 1'b1;
               first_in  = v_ff;
               sum_in    = SUMW'(v_ff) * SUMW'(n);
               sq_in     = SQW'(vv_ff) * SQW'(n);
            end else begin
               sum_in = sum_ff + SUMW'(v_ff) - SUMW'(old_ff);
               sq_in  = sq_ff + SQW'(vv_ff) - SQW'(oo_ff);
               if (pos_next >= n) begin
                  wpos_in    = '0;
                  wrapped_in = 1'b1;
               end else begin
                  wpos_in = PW'(pos_next);
               end
            end
         end
         WMV_LOAD: begin
            dq_s_in  = SQW'(sum_ff);
            dq_q_in  = sq_ff;
            rem_s_in = '0;
            rem_q_in = '0;
            cnt_in   = '0;
         end
         WMV_DIVIDE: begin
            rem_s_in = ge_s ? NW'(rs_s - {1'b0, n}) : NW'(rs_s);
            rem_q_in = ge_q ? NW'(rs_q - {1'b0, n}) : NW'(rs_q);
            dq_s_in  = {dq_s_ff[SQW-2:0], ge_s};
            dq_q_in  = {dq_q_ff[SQW-2:0], ge_q};
            cnt_in   = cnt_ff + CNTW'(1);
         end
         WMV_SQUARE: begin
            m2_in = SQ2'(mean_q) * SQ2'(mean_q);
         end
         WMV_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mean_in      = WMV_MEAN_W'(mean_q);
               var_in       = (msq_q >= m2_ff) ? WMV_VAR_W'(msq_q - m2_ff) : '0;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WMV_IDLE;
         wl_ff        <= WMV_LEN_W'(WMV_LEN_RESET);
         wpos_ff      <= '0;
         primed_ff    <= 1'b0;
         wrapped_ff   <= 1'b0;
         first_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         wpos_ff      <= wpos_in;
         primed_ff    <= primed_in;
         wrapped_ff   <= wrapped_in;
         first_ff     <= first_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      old_ff   <= old_in;
      vv_ff    <= vv_in;
      oo_ff    <= oo_in;
      dq_s_ff  <= dq_s_in;
      dq_q_ff  <= dq_q_in;
      rem_s_ff <= rem_s_in;
      rem_q_ff <= rem_q_in;
      cnt_ff   <= cnt_in;
      m2_ff    <= m2_in;
      mean_ff  <= mean_in;
      var_ff   <= var_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[pos] <= v_ff;
      end
      rd_ff <= ring[pos];
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.window_mean     = mean_ff;
   assign rsp_ch.window_variance = var_ff;

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == WMV_READ)
      else $error("sample transfer did not start a ring read");

   a_no_sample_with_csr: assert property (@(posedge clock) disable iff (reset)
      csr_fire |-> !req_fire)
      else $error("sample and window length transfer in the same cycle");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == WMV_DIVIDE |-> (rem_s_ff < n) && (rem_q_ff < n))
      else $error("divider remainder not below window length");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == WMV_FINISH)
      else $error("result presented outside the finish step");

endmodule
